>>> rtl/i2c_master_bit_engine_assert.svh
// Assertion macros shared by the I2C master bit engine RTL
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define I2CM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CM_ASSERT(lbl, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/i2cm_pkg.sv
// Types, codes and constants shared by the I2C master bit engine
package i2cm_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd500;
	localparam logic [7:0]  ACK_POLL_RST    = 8'd254;

	localparam logic [7:0] REG_HALF_PERIOD = 8'd0;
	localparam logic [7:0] REG_ACK_POLL    = 8'd1;

	localparam logic [2:0] OP_START     = 3'd1;
	localparam logic [2:0] OP_RESTART   = 3'd2;
	localparam logic [2:0] OP_STOP      = 3'd3;
	localparam logic [2:0] OP_WRITE     = 3'd4;
	localparam logic [2:0] OP_READ_ACK  = 3'd5;
	localparam logic [2:0] OP_READ_NACK = 3'd6;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_RESTART,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ_ACK,
		CMD_READ_NACK
	} cmd_t;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_S_WAIT,
		PH_RS1,
		PH_RS2,
		PH_RS3,
		PH_P1,
		PH_P2,
		PH_P3,
		PH_W_LOW,
		PH_W_HIGH,
		PH_A_LOW,
		PH_A_HIGH,
		PH_A_POLL,
		PH_R_LOW,
		PH_R_HIGH,
		PH_RA_LOW,
		PH_RA_HIGH
	} phase_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] wbyte;
		logic       sda;
	} item_t;

endpackage

>>> rtl/i2c_master_bit_engine.sv
// A tick's result is offered from the result register once the engine has taken the tick from the queue.
// Throughput: one tick per cycle unless the output stalls; the engine applies one full tick step per tick.
// A queue of QueueDepth entries parts intake from the engine, the result register parts
// the engine from the output. Reset (arst_n low) empties the queue, sets the engine idle
// with SCL and SDA released, ack 1, read byte 0, half period 500 and poll limit 254.
// Top level of the I2C master bit engine
module i2c_master_bit_engine
	import i2cm_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  write_byte,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_out,
	output logic        sda_out,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_byte,
	output logic        ack_bit,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	i2cm_front #(
		.Depth(QueueDepth)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.write_byte (write_byte),
		.sda_in     (sda_in),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl_out   (scl_out),
		.sda_out   (sda_out),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.read_byte (read_byte),
		.ack_bit   (ack_bit)
	);

endmodule

>>> rtl/i2cm_front.sv
// Front end: accepts tick items, decodes the operation and queues them
`include "i2c_master_bit_engine_assert.svh"
module i2cm_front
	import i2cm_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [7:0] write_byte,
	input  logic       sda_in,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	item_t            mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	cmd_t             cmd_dec;
	item_t            item_in;
	logic             push;

	always_comb begin
		unique case (operation)
			OP_START:     cmd_dec = CMD_START;
			OP_RESTART:   cmd_dec = CMD_RESTART;
			OP_STOP:      cmd_dec = CMD_STOP;
			OP_WRITE:     cmd_dec = CMD_WRITE;
			OP_READ_ACK:  cmd_dec = CMD_READ_ACK;
			OP_READ_NACK: cmd_dec = CMD_READ_NACK;
			default:      cmd_dec = CMD_NONE;
		endcase
	end

	assign item_in  = '{cmd: cmd_dec, wbyte: write_byte, sda: sda_in};
	assign in_ready = (count_q != CntW'(Depth));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`I2CM_ASSERT(a_count_bound, (count_q <= CntW'(Depth)), "queue count above depth")
	`I2CM_ASSERT(a_pop_nonempty, (q_pop |-> count_q != '0), "pop from empty queue")
	`I2CM_ASSERT(a_push_grows, ((push && !q_pop) |=> count_q == $past(count_q) + 1'b1), "queue count did not grow on push")

endmodule

>>> rtl/i2cm_back.sv
// Back end: bit engine state machine, configuration registers and result register
`include "i2c_master_bit_engine_assert.svh"
module i2cm_back
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_out,
	output logic        sda_out,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_byte,
	output logic        ack_bit
);

	logic [15:0] half_q;
	logic [7:0]  lim_q;
	phase_t      phase_q, phase_d;
	cmd_t        cmd_q, cmd_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] delay_q, delay_d;
	logic [7:0]  poll_q, poll_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        ack_q, ack_d;
	logic [7:0]  rd_q, rd_d;
	logic        done_q, done_d;
	logic        out_valid_q;

	logic        fire;
	logic [15:0] dload;
	logic [15:0] dec;
	logic        dzero;
	logic [7:0]  lim;
	logic [7:0]  poll_inc;
	logic        poll_end;
	logic [3:0]  bit_inc;
	logic        last_bit;

	assign fire      = q_valid && (!out_valid_q || out_ready);
	assign q_pop     = fire;
	assign cfg_ready = 1'b1;

	assign dload    = (half_q == '0) ? 16'd1 : half_q;
	assign dec      = delay_q - 16'd1;
	assign dzero    = (dec == '0);
	assign lim      = (lim_q == '0) ? 8'd1 : lim_q;
	assign poll_inc = poll_q + 8'd1;
	assign poll_end = (poll_inc >= lim);
	assign bit_inc  = bit_q + 4'd1;
	assign last_bit = (bit_inc >= 4'd8);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				unique case (q_item.cmd)
					CMD_START:     phase_d = PH_S_WAIT;
					CMD_RESTART:   phase_d = PH_RS1;
					CMD_STOP:      phase_d = PH_P1;
					CMD_WRITE:     phase_d = PH_W_LOW;
					CMD_READ_ACK,
					CMD_READ_NACK: phase_d = PH_R_LOW;
					default:       phase_d = PH_IDLE;
				endcase
			end
			PH_A_POLL: if (!q_item.sda || poll_end) phase_d = PH_IDLE;
			PH_S_WAIT, PH_RS3, PH_P3, PH_RA_HIGH: if (dzero) phase_d = PH_IDLE;
			PH_RS1:    if (dzero) phase_d = PH_RS2;
			PH_RS2:    if (dzero) phase_d = PH_RS3;
			PH_P1:     if (dzero) phase_d = PH_P2;
			PH_P2:     if (dzero) phase_d = PH_P3;
			PH_W_LOW:  if (dzero) phase_d = PH_W_HIGH;
			PH_W_HIGH: if (dzero) phase_d = last_bit ? PH_A_LOW : PH_W_LOW;
			PH_A_LOW:  if (dzero) phase_d = PH_A_HIGH;
			PH_A_HIGH: if (dzero) phase_d = PH_A_POLL;
			PH_R_LOW:  if (dzero) phase_d = PH_R_HIGH;
			PH_R_HIGH: if (dzero) phase_d = last_bit ? PH_RA_LOW : PH_R_LOW;
			PH_RA_LOW: if (dzero) phase_d = PH_RA_HIGH;
			default:   phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		cmd_d   = cmd_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		delay_d = delay_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		rd_d    = rd_q;
		done_d  = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (q_item.cmd != CMD_NONE) begin
					cmd_d   = q_item.cmd;
					delay_d = dload;
					unique case (q_item.cmd)
						CMD_START, CMD_STOP: sda_d = 1'b0;
						CMD_RESTART:         sda_d = 1'b1;
						CMD_WRITE: begin
							shift_d = q_item.wbyte;
							bit_d   = '0;
						end
						default: begin
							sda_d   = 1'b1;
							shift_d = '0;
							bit_d   = '0;
						end
					endcase
				end
			end
			PH_A_POLL: begin
				if (!q_item.sda) begin
					ack_d  = 1'b0;
					scl_d  = 1'b0;
					done_d = 1'b1;
				end else begin
					poll_d = poll_inc;
					if (poll_end) begin
						ack_d  = 1'b1;
						scl_d  = 1'b0;
						done_d = 1'b1;
					end
				end
			end
			default: begin
				delay_d = dec;
				if (dzero) begin
					unique case (phase_q)
						PH_S_WAIT, PH_RS3: begin
							scl_d  = 1'b0;
							done_d = 1'b1;
						end
						PH_RS1, PH_P1, PH_R_LOW: begin
							scl_d   = 1'b1;
							delay_d = dload;
						end
						PH_RS2: begin
							sda_d   = 1'b0;
							delay_d = dload;
						end
						PH_P2: begin
							sda_d   = 1'b1;
							delay_d = dload;
						end
						PH_P3: done_d = 1'b1;
						PH_W_LOW: begin
							sda_d   = shift_q[7];
							scl_d   = 1'b1;
							delay_d = dload;
						end
						PH_W_HIGH: begin
							scl_d   = 1'b0;
							shift_d = {shift_q[6:0], 1'b0};
							bit_d   = bit_inc;
							delay_d = dload;
						end
						PH_A_LOW: begin
							sda_d   = 1'b1;
							scl_d   = 1'b1;
							delay_d = dload;
						end
						PH_A_HIGH: poll_d = '0;
						PH_R_HIGH: begin
							shift_d = {shift_q[6:0], q_item.sda};
							scl_d   = 1'b0;
							bit_d   = bit_inc;
							delay_d = dload;
							if (last_bit) begin
								rd_d = {shift_q[6:0], q_item.sda};
							end
						end
						PH_RA_LOW: begin
							sda_d   = (cmd_q == CMD_READ_ACK) ? 1'b0 : 1'b1;
							scl_d   = 1'b1;
							delay_d = dload;
						end
						PH_RA_HIGH: begin
							scl_d  = 1'b0;
							sda_d  = 1'b1;
							done_d = 1'b1;
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= HALF_PERIOD_RST;
			lim_q       <= ACK_POLL_RST;
			phase_q     <= PH_IDLE;
			cmd_q       <= CMD_NONE;
			bit_q       <= '0;
			shift_q     <= '0;
			delay_q     <= '0;
			poll_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b1;
			rd_q        <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_HALF_PERIOD: half_q <= cfg_data;
					REG_ACK_POLL:    lim_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (fire) begin
				phase_q <= phase_d;
				cmd_q   <= cmd_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				delay_q <= delay_d;
				poll_q  <= poll_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				ack_q   <= ack_d;
				rd_q    <= rd_d;
				done_q  <= done_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out   = scl_q;
	assign sda_out   = sda_q;
	assign busy_res  = (phase_q != PH_IDLE);
	assign done_res  = done_q;
	assign read_byte = rd_q;
	assign ack_bit   = ack_q;

	`I2CM_ASSERT_ALWAYS(a_done_idle, (done_q |-> phase_q == PH_IDLE), "done while engine busy")
	`I2CM_ASSERT(a_hold_no_fire, (!fire |=> $stable(phase_q) && $stable(delay_q)), "engine moved without a tick")
	`I2CM_ASSERT(a_delay_live, ((phase_q != PH_IDLE && phase_q != PH_A_POLL) |-> delay_q != '0), "zero delay in a wait phase")

endmodule

>>> tb/i2cm_tick_check_pkg.sv
// Tick-level predictor and result checker for the I2C master bit engine testbench
`timescale 1ns / 100ps

package i2cm_tick_check_pkg;
	import i2cm_pkg::*;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rbyte;
		logic       ack;
	} tick_res_t;

	class bit_engine_model;
		logic [15:0] half_period;
		logic [7:0]  poll_limit;
		phase_t      step_ph;
		logic [2:0]  cur_cmd;
		logic [3:0]  bit_cnt;
		logic [7:0]  shreg;
		logic [15:0] dly;
		logic [7:0]  poll_cnt;
		logic        scl;
		logic        sda;
		logic        ack;
		logic [7:0]  rd_hold;
		tick_res_t   expected_ticks[$];
		int          failures;

		function new();
			half_period = HALF_PERIOD_RST;
			poll_limit  = ACK_POLL_RST;
			step_ph     = PH_IDLE;
			cur_cmd     = '0;
			bit_cnt     = '0;
			shreg       = '0;
			dly         = '0;
			poll_cnt    = '0;
			scl         = 1'b1;
			sda         = 1'b1;
			ack         = 1'b1;
			rd_hold     = '0;
			failures    = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [15:0] val);
			if (idx == REG_HALF_PERIOD) begin
				half_period = val;
			end else if (idx == REG_ACK_POLL) begin
				poll_limit = val[7:0];
			end
		endfunction

		function bit busy();
			return step_ph != PH_IDLE;
		endfunction

		function bit polling();
			return step_ph == PH_A_POLL;
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		// a zero half period counts as one tick
		function void reload(phase_t nxt);
			dly = (half_period != 0) ? half_period : 16'd1;
			step_ph = nxt;
		endfunction

		function void take_tick(logic [2:0] op, logic [7:0] wb, logic sda_i);
			tick_res_t  r;
			logic       done;
			logic [7:0] lim;
			done = 1'b0;
			if (step_ph == PH_IDLE) begin
				if (op >= OP_START && op <= OP_READ_NACK) begin
					cur_cmd = op;
					case (op)
						OP_START: begin
							sda = 1'b0;
							reload(PH_S_WAIT);
						end
						OP_RESTART: begin
							sda = 1'b1;
							reload(PH_RS1);
						end
						OP_STOP: begin
							sda = 1'b0;
							reload(PH_P1);
						end
						OP_WRITE: begin
							shreg = wb;
							bit_cnt = '0;
							reload(PH_W_LOW);
						end
						default: begin
							sda = 1'b1;
							shreg = '0;
							bit_cnt = '0;
							reload(PH_R_LOW);
						end
					endcase
				end
			end else if (step_ph == PH_A_POLL) begin
				if (!sda_i) begin
					ack = 1'b0;
					scl = 1'b0;
					step_ph = PH_IDLE;
					done = 1'b1;
				end else begin
					lim = (poll_limit != 0) ? poll_limit : 8'd1;
					poll_cnt = poll_cnt + 8'd1;
					if (poll_cnt >= lim) begin
						ack = 1'b1;
						scl = 1'b0;
						step_ph = PH_IDLE;
						done = 1'b1;
					end
				end
			end else begin
				dly = dly - 16'd1;
				if (dly == 0) begin
					case (step_ph)
						PH_S_WAIT: begin
							scl = 1'b0;
							step_ph = PH_IDLE;
							done = 1'b1;
						end
						PH_RS1: begin
							scl = 1'b1;
							reload(PH_RS2);
						end
						PH_RS2: begin
							sda = 1'b0;
							reload(PH_RS3);
						end
						PH_RS3: begin
							scl = 1'b0;
							step_ph = PH_IDLE;
							done = 1'b1;
						end
						PH_P1: begin
							scl = 1'b1;
							reload(PH_P2);
						end
						PH_P2: begin
							sda = 1'b1;
							reload(PH_P3);
						end
						PH_P3: begin
							step_ph = PH_IDLE;
							done = 1'b1;
						end
						PH_W_LOW: begin
							sda = shreg[7];
							scl = 1'b1;
							reload(PH_W_HIGH);
						end
						PH_W_HIGH: begin
							scl = 1'b0;
							shreg = {shreg[6:0], 1'b0};
							bit_cnt = bit_cnt + 4'd1;
							if (bit_cnt >= 8) begin
								reload(PH_A_LOW);
							end else begin
								reload(PH_W_LOW);
							end
						end
						PH_A_LOW: begin
							sda = 1'b1;
							scl = 1'b1;
							reload(PH_A_HIGH);
						end
						PH_A_HIGH: begin
							poll_cnt = '0;
							step_ph = PH_A_POLL;
						end
						PH_R_LOW: begin
							scl = 1'b1;
							reload(PH_R_HIGH);
						end
						PH_R_HIGH: begin
							shreg = {shreg[6:0], sda_i};
							scl = 1'b0;
							bit_cnt = bit_cnt + 4'd1;
							if (bit_cnt >= 8) begin
								rd_hold = shreg;
								reload(PH_RA_LOW);
							end else begin
								reload(PH_R_LOW);
							end
						end
						PH_RA_LOW: begin
							sda = (cur_cmd == OP_READ_ACK) ? 1'b0 : 1'b1;
							scl = 1'b1;
							reload(PH_RA_HIGH);
						end
						PH_RA_HIGH: begin
							scl = 1'b0;
							sda = 1'b1;
							step_ph = PH_IDLE;
							done = 1'b1;
						end
						default: begin
							step_ph = PH_IDLE;
						end
					endcase
				end
			end
			r.scl   = scl;
			r.sda   = sda;
			r.busy  = (step_ph != PH_IDLE);
			r.done  = done;
			r.rbyte = rd_hold;
			r.ack   = ack;
			expected_ticks.push_back(r);
		endfunction

		function void match_tick(tick_res_t got);
			tick_res_t want;
			if (expected_ticks.size() == 0) begin
				$error("result transfer with no tick outstanding");
				failures++;
				return;
			end
			want = expected_ticks.pop_front();
			if (got.scl !== want.scl) begin
				$error("scl_out: expected %0d, actual %0d", want.scl, got.scl);
				failures++;
			end
			if (got.sda !== want.sda) begin
				$error("sda_out: expected %0d, actual %0d", want.sda, got.sda);
				failures++;
			end
			if (got.busy !== want.busy) begin
				$error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
				failures++;
			end
			if (got.done !== want.done) begin
				$error("done_res: expected %0d, actual %0d", want.done, got.done);
				failures++;
			end
			if (got.rbyte !== want.rbyte) begin
				$error("read_byte: expected 0x%02h, actual 0x%02h", want.rbyte, got.rbyte);
				failures++;
			end
			if (got.ack !== want.ack) begin
				$error("ack_bit: expected %0d, actual %0d", want.ack, got.ack);
				failures++;
			end
		endfunction
	endclass

endpackage

>>> tb/tb.sv
// Testbench top for the I2C master bit engine: tick stimulus, register writes and result checks
`timescale 1ns / 100ps

module tb;
	import i2cm_pkg::*;
	import i2cm_tick_check_pkg::*;

	localparam logic [2:0] OP_NONE     = CMD_NONE;
	localparam logic [2:0] OP_UNUSED   = 3'd7;
	localparam logic [1:0] SDA_LOW     = 2'd0;
	localparam logic [1:0] SDA_HIGH    = 2'd1;
	localparam logic [1:0] SDA_RAND    = 2'd2;
	localparam int         NO_ACK      = -1;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         LONG_HOLD   = 150;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  operation;
	logic [7:0]  write_byte;
	logic        sda_in;
	logic        out_valid;
	logic        out_ready;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_byte;
	logic        ack_bit;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;

	bit_engine_model engine;
	tick_res_t       seen;
	int              ticks_sent;
	bit              gaps_on;
	bit              long_hold;

	i2c_master_bit_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.write_byte(write_byte),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_byte(read_byte),
		.ack_bit(ack_bit),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic pick_sda(logic [1:0] mode);
		case (mode)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom);
		endcase
	endfunction

	function automatic int ack_plan();
		if ($urandom_range(0, 3) == 0) begin
			return NO_ACK;
		end
		return $urandom_range(0, 6);
	endfunction

	task automatic send_tick(input logic [2:0] op, input logic [7:0] wb, input logic sda_v);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		write_byte <= wb;
		sda_in     <= sda_v;
		do @(posedge clk); while (!in_ready);
		engine.take_tick(op, wb, sda_v);
		ticks_sent++;
	endtask

	// ack_after: poll ticks with SDA high before pulling it low, NO_ACK to time out
	task automatic run_cmd(input logic [2:0] op, input logic [7:0] wb, input logic [1:0] mode,
			input int ack_after);
		int         polls;
		logic       s;
		logic [2:0] fop;
		polls = 0;
		send_tick(op, wb, pick_sda(mode));
		while (engine.busy()) begin
			fop = OP_NONE;
			if ($urandom_range(0, 9) == 0) begin
				fop = 3'($urandom_range(1, 7));
			end
			if (engine.polling()) begin
				s = !(ack_after != NO_ACK && polls >= ack_after);
				polls++;
			end else begin
				s = pick_sda(mode);
			end
			send_tick(fop, 8'($urandom), s);
		end
	endtask

	task automatic set_reg(input logic [7:0] idx, input logic [15:0] val);
		in_valid <= 1'b0;
		while (engine.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		engine.write_reg(idx, val);
	endtask

	task automatic random_transfer();
		int n;
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				if ($urandom_range(0, 1) == 0) begin
					send_tick($urandom_range(0, 1) ? OP_UNUSED : OP_NONE, 8'($urandom),
						1'($urandom));
				end else begin
					run_cmd(3'($urandom_range(1, 6)), 8'($urandom), SDA_RAND, ack_plan());
				end
			end
			return;
		end
		run_cmd(OP_START, 8'($urandom), SDA_RAND, NO_ACK);
		run_cmd(OP_WRITE, 8'($urandom), SDA_RAND, ack_plan());
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: run_cmd(OP_WRITE, 8'($urandom), SDA_RAND, ack_plan());
				1: run_cmd(OP_READ_ACK, 8'($urandom), SDA_RAND, NO_ACK);
				2: run_cmd(OP_READ_NACK, 8'($urandom), SDA_RAND, NO_ACK);
				default: begin
					run_cmd(OP_RESTART, 8'($urandom), SDA_RAND, NO_ACK);
					run_cmd(OP_WRITE, 8'($urandom), SDA_RAND, ack_plan());
				end
			endcase
		end
		run_cmd(OP_STOP, 8'($urandom), SDA_RAND, NO_ACK);
	endtask

	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = {scl_out, sda_out, busy_res, done_res, read_byte, ack_bit};
			engine.match_tick(seen);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		operation  <= OP_NONE;
		write_byte <= 8'h00;
		sda_in     <= 1'b1;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_HALF_PERIOD;
		cfg_data   <= 16'h0000;
		gaps_on    = 1'b0;
		long_hold  = 1'b0;
		ticks_sent = 0;
		engine     = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_cmd(OP_START, 8'h00, SDA_RAND, NO_ACK);
		set_reg(REG_HALF_PERIOD, 16'd1);
		run_cmd(OP_STOP, 8'hFF, SDA_RAND, NO_ACK);

		gaps_on = 1'b1;
		run_cmd(OP_START, 8'h00, SDA_RAND, NO_ACK);
		run_cmd(OP_WRITE, 8'h00, SDA_RAND, 0);
		run_cmd(OP_WRITE, 8'hFF, SDA_RAND, NO_ACK);
		run_cmd(OP_WRITE, 8'hA5, SDA_RAND, 3);
		run_cmd(OP_RESTART, 8'h00, SDA_RAND, NO_ACK);
		run_cmd(OP_READ_ACK, 8'hFF, SDA_LOW, NO_ACK);
		run_cmd(OP_READ_NACK, 8'h00, SDA_HIGH, NO_ACK);
		send_tick(OP_UNUSED, 8'h5A, 1'b0);
		send_tick(OP_NONE, 8'hFF, 1'b1);
		run_cmd(OP_STOP, 8'h00, SDA_RAND, NO_ACK);

		set_reg(REG_HALF_PERIOD, 16'd0);
		set_reg(REG_ACK_POLL, 16'd0);
		run_cmd(OP_WRITE, 8'h5A, SDA_RAND, NO_ACK);
		run_cmd(OP_WRITE, 8'h3C, SDA_RAND, 0);
		run_cmd(OP_READ_ACK, 8'h00, SDA_RAND, NO_ACK);

		set_reg(REG_HALF_PERIOD, 16'd2);
		set_reg(REG_ACK_POLL, 16'd255);
		long_hold = 1'b1;
		run_cmd(OP_WRITE, 8'h81, SDA_RAND, 6);
		run_cmd(OP_WRITE, 8'h7E, SDA_RAND, 2);

		do begin
			set_reg(REG_HALF_PERIOD, ($urandom_range(0, 4) == 0) ? 16'd0 :
				16'($urandom_range(1, 4)));
			set_reg(REG_ACK_POLL, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) :
				16'($urandom_range(0, 6)));
			repeat (3) begin
				gaps_on = ($urandom_range(0, 2) != 0);
				random_transfer();
			end
		end while (ticks_sent < 1150);

		gaps_on = 1'b0;
		set_reg(REG_HALF_PERIOD, 16'd40);
		run_cmd(OP_START, 8'($urandom), SDA_RAND, NO_ACK);
		set_reg(REG_HALF_PERIOD, 16'd3);
		random_transfer();

		in_valid <= 1'b0;
		while (engine.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (engine.failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_bit_engine.sv
tb/i2cm_tick_check_pkg.sv
tb/tb.sv
